>>> sv/btk_pkg.sv
// ============================================================================
// btk_pkg: shared types and constants of the box track filter
// Opcodes, sequencer states, shared-unit command and the hit micro-op table.
// ============================================================================
`default_nettype none

package btk_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COV_WIDTH_DEF   = 48;
   localparam int COV_FRAC        = 24;
   localparam logic [7:0]  LIFE_CAP_RESET = 8'd30;
   localparam logic [23:0] COV_Q   = 24'd167772;    // 0.01 in Q24.24
   localparam logic [23:0] COV_R   = 24'd1677722;   // 0.1 in Q24.24
   localparam logic [24:0] COV_ONE = 25'd16777216;  // 1.0 in Q24.24
   localparam logic [17:0] ONE_Q16 = 18'd65536;

   localparam int HIT_STEPS = 22;
   localparam int STEP_W    = 5;

   typedef enum logic [1:0] {
      OPC_INIT    = 2'd0,
      OPC_PREDICT = 2'd1,
      OPC_HIT     = 2'd2,
      OPC_MISS    = 2'd3
   } opcode_type;

   typedef enum logic {
      UK_MUL = 1'b0,
      UK_DIV = 1'b1
   } unit_kind_type;

   typedef struct packed {
      logic          start;
      unit_kind_type kind;
      logic          narrow;   // saturate to coordinate width
   } unit_cmd_type;

   typedef enum logic [2:0] {
      SRC_A, SRC_B, SRC_C, SRC_D, SRC_K0, SRC_K1, SRC_E, SRC_S
   } src_type;

   typedef enum logic [2:0] {
      DST_K0, DST_K1, DST_SP, DST_SV, DST_PA, DST_PB, DST_PC, DST_PD
   } dst_type;

   typedef struct packed {
      unit_kind_type kind;
      logic [1:0]    axis;
      logic          first;    // latch innovation and its variance
      src_type       src_a;
      src_type       src_b;
      dst_type       dst;
   } uop_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_PRED1,
      ST_PRED2,
      ST_PRED3,
      ST_PRED4,
      ST_SHOW,
      ST_ISSUE,
      ST_LAUNCH,
      ST_WAIT,
      ST_EMIT
   } state_type;

   function automatic uop_type mk_uop(input unit_kind_type kd, input logic [1:0] ax,
                                      input logic f, input src_type a, input src_type b,
                                      input dst_type d);
      uop_type u;
      u.kind  = kd;
      u.axis  = ax;
      u.first = f;
      u.src_a = a;
      u.src_b = b;
      u.dst   = d;
      return u;
   endfunction

   // Order matters: every entry is read before the step that overwrites it.
   function automatic uop_type pair_uop(input logic [1:0] ax, input logic [2:0] j);
      uop_type u;
      case (j)
         3'd0: u = mk_uop(UK_DIV, ax, 1'b1, SRC_A,  SRC_S, DST_K0);
         3'd1: u = mk_uop(UK_DIV, ax, 1'b0, SRC_C,  SRC_S, DST_K1);
         3'd2: u = mk_uop(UK_MUL, ax, 1'b0, SRC_K0, SRC_E, DST_SP);
         3'd3: u = mk_uop(UK_MUL, ax, 1'b0, SRC_K1, SRC_E, DST_SV);
         3'd4: u = mk_uop(UK_MUL, ax, 1'b0, SRC_K1, SRC_B, DST_PD);
         3'd5: u = mk_uop(UK_MUL, ax, 1'b0, SRC_K1, SRC_A, DST_PC);
         3'd6: u = mk_uop(UK_MUL, ax, 1'b0, SRC_K0, SRC_B, DST_PB);
         default: u = mk_uop(UK_MUL, ax, 1'b0, SRC_K0, SRC_A, DST_PA);
      endcase
      return u;
   endfunction

   function automatic uop_type hit_uop(input logic [STEP_W-1:0] step);
      uop_type u;
      case (step)
         5'd16: u = mk_uop(UK_DIV, 2'd2, 1'b1, SRC_A,  SRC_S, DST_K0);
         5'd17: u = mk_uop(UK_MUL, 2'd2, 1'b0, SRC_K0, SRC_E, DST_SP);
         5'd18: u = mk_uop(UK_MUL, 2'd2, 1'b0, SRC_K0, SRC_A, DST_PA);
         5'd19: u = mk_uop(UK_DIV, 2'd3, 1'b1, SRC_A,  SRC_S, DST_K0);
         5'd20: u = mk_uop(UK_MUL, 2'd3, 1'b0, SRC_K0, SRC_E, DST_SP);
         5'd21: u = mk_uop(UK_MUL, 2'd3, 1'b0, SRC_K0, SRC_A, DST_PA);
         default: u = pair_uop({1'b0, step[3]}, step[2:0]);
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

>>> sv/box_track_kalman_life_update_core.sv
// ============================================================================
// box_track_kalman_life_update_core: single box tracker with life counter
// Constant-velocity Kalman filter on (cx, cy, w, h, vx, vy), life and streak.
// ============================================================================
// One item at a time. Predict runs four saturating add passes over the two
// position/velocity pairs, then forms the box. Hit runs 22 micro-ops through
// one shared iterative multiply/divide unit: 6 divides and 16 multiplies.
// req_stall stays high from acceptance until the result is loaded into the
// output register; the next item is taken while a result still waits there.
// ============================================================================
`default_nettype none

module box_track_kalman_life_update_core #(
   parameter int COORD_WIDTH = btk_pkg::COORD_WIDTH_DEF,
   parameter int COV_WIDTH   = btk_pkg::COV_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // config
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_box_x,
   input  wire logic [31:0] req_box_y,
   input  wire logic [30:0] req_box_w,
   input  wire logic [30:0] req_box_h,
   input  wire logic [7:0]  req_class_tag,
   input  wire logic [15:0] req_confidence,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [30:0]      rsp_out_w,
   output logic [30:0]      rsp_out_h,
   output logic [7:0]       rsp_out_class,
   output logic [15:0]      rsp_out_score,
   output logic [7:0]       rsp_life_now,
   output logic             rsp_dead,
   output logic             rsp_healthy
);
   import btk_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int VW = COV_WIDTH;
   localparam int OW = (CW > VW) ? CW : VW;
   localparam int LW = ((CW > 34) ? CW : 34) + 2;   // coordinate scratch width
   localparam int VL = VW + 2;                       // covariance scratch width

   localparam logic signed [LW-1:0] C_MAX   = $signed({{(LW-CW+1){1'b0}}, {(CW-1){1'b1}}});
   localparam logic signed [LW-1:0] C_MIN   = ~C_MAX;
   localparam logic signed [LW-1:0] S32_MAX = $signed({{(LW-31){1'b0}}, {31{1'b1}}});
   localparam logic signed [LW-1:0] S32_MIN = ~S32_MAX;
   localparam logic signed [LW-1:0] ONE_L   = LW'(ONE_Q16);
   localparam logic signed [VL-1:0] V_MAX   = $signed({3'b000, {(VW-1){1'b1}}});
   localparam logic signed [VL-1:0] V_MIN   = ~V_MAX;
   localparam logic signed [VL-1:0] Q_L     = VL'(COV_Q);
   localparam logic signed [VL-1:0] R_L     = VL'(COV_R);

   function automatic logic signed [CW-1:0] sat_c(input logic signed [LW-1:0] x);
      logic signed [LW-1:0] y;
      y = (x > C_MAX) ? C_MAX : ((x < C_MIN) ? C_MIN : x);
      return y[CW-1:0];
   endfunction

   function automatic logic signed [VW-1:0] sat_v(input logic signed [VL-1:0] x);
      logic signed [VL-1:0] y;
      y = (x > V_MAX) ? V_MAX : ((x < V_MIN) ? V_MIN : x);
      return y[VW-1:0];
   endfunction

   function automatic logic [31:0] sat_32(input logic signed [LW-1:0] x);
      logic signed [LW-1:0] y;
      y = (x > S32_MAX) ? S32_MAX : ((x < S32_MIN) ? S32_MIN : x);
      return y[31:0];
   endfunction

   function automatic logic signed [LW-1:0] cx(input logic signed [CW-1:0] x);
      return LW'(x);
   endfunction

   function automatic logic signed [VL-1:0] vx(input logic signed [VW-1:0] x);
      return VL'(x);
   endfunction

   // ---------------------------------------------------------------- state
   state_type            state_ff, state_in;
   logic [7:0]           life_cap_ff;

   opcode_type           op_ff;
   logic [31:0]          bx_ff, by_ff;
   logic [30:0]          bw_ff, bh_ff;
   logic [7:0]           cls_ff;
   logic [15:0]          conf_ff;

   logic signed [CW-1:0] pos_ff [4];     // cx, cy, w, h
   logic signed [CW-1:0] vel_ff [2];     // vx, vy
   logic signed [VW-1:0] pa_ff  [4];     // diagonal of each axis
   logic signed [VW-1:0] pb_ff  [2];     // pos/vel cross terms
   logic signed [VW-1:0] pc_ff  [2];
   logic signed [VW-1:0] pd_ff  [2];     // velocity variance
   logic signed [VW-1:0] tmp_ff [2];
   logic [1:0]           hs_ff;
   logic [7:0]           life_ff;
   logic [7:0]           class_ff;
   logic [15:0]          score_ff;
   logic [31:0]          shown_x_ff, shown_y_ff;
   logic [30:0]          shown_w_ff, shown_h_ff;
   logic                 dead_ff;

   logic [STEP_W-1:0]    step_ff;
   logic signed [VW-1:0] s_ff, k0_ff, k1_ff;
   logic signed [CW-1:0] e_ff;

   logic                 rsp_valid_ff;
   logic [31:0]          rsp_x_ff, rsp_y_ff;
   logic [30:0]          rsp_w_ff, rsp_h_ff;
   logic [7:0]           rsp_class_ff, rsp_life_ff;
   logic [15:0]          rsp_score_ff;
   logic                 rsp_dead_ff, rsp_healthy_ff;

   // -------------------------------------------------------- control decode
   logic                 accept;
   logic                 emit_go;
   logic                 last_step;
   unit_cmd_type         unit_cmd;
   logic signed [OW-1:0] unit_a, unit_b, unit_res;
   logic                 unit_done;

   uop_type              uop;
   logic [1:0]           ax;
   logic signed [VW-1:0] cur_a, cur_b, cur_c, cur_d;
   logic signed [CW-1:0] cur_p, z_cur, zx, zy, zw, zh;
   logic signed [VW-1:0] s_calc;
   logic signed [CW-1:0] e_calc;
   logic signed [CW-1:0] res_c;
   logic signed [VW-1:0] res_v;

   logic [1:0]           hs_hit;
   logic [8:0]           life_sum;
   logic [7:0]           life_hit, life_miss;
   logic signed [LW-1:0] w_fl, h_fl;

   assign uop   = hit_uop(step_ff);
   assign ax    = uop.axis;
   assign cur_a = pa_ff[ax];
   assign cur_b = pb_ff[ax[0]];
   assign cur_c = pc_ff[ax[0]];
   assign cur_d = pd_ff[ax[0]];
   assign cur_p = pos_ff[ax];

   // measured center and size
   assign zx = sat_c(LW'($signed(bx_ff)) + LW'($signed({2'b00, bw_ff[30:1]})));
   assign zy = sat_c(LW'($signed(by_ff)) + LW'($signed({2'b00, bh_ff[30:1]})));
   assign zw = sat_c(LW'($signed({1'b0, bw_ff})));
   assign zh = sat_c(LW'($signed({1'b0, bh_ff})));

   always_comb begin
      case (ax)
         2'd0:    z_cur = zx;
         2'd1:    z_cur = zy;
         2'd2:    z_cur = zw;
         default: z_cur = zh;
      endcase
   end

   // innovation variance is kept strictly positive
   assign s_calc = sat_v(((cur_a > 0) ? vx(cur_a) : VL'(0)) + R_L);
   assign e_calc = sat_c(cx(z_cur) - cx(cur_p));

   function automatic logic signed [OW-1:0] pick(input src_type sel,
         input logic signed [VW-1:0] a, input logic signed [VW-1:0] b,
         input logic signed [VW-1:0] c, input logic signed [VW-1:0] d,
         input logic signed [VW-1:0] k0, input logic signed [VW-1:0] k1,
         input logic signed [CW-1:0] e, input logic signed [VW-1:0] s);
      logic signed [OW-1:0] r;
      case (sel)
         SRC_A:   r = OW'(a);
         SRC_B:   r = OW'(b);
         SRC_C:   r = OW'(c);
         SRC_D:   r = OW'(d);
         SRC_K0:  r = OW'(k0);
         SRC_K1:  r = OW'(k1);
         SRC_E:   r = OW'(e);
         default: r = OW'(s);
      endcase
      return r;
   endfunction

   assign unit_a = pick(uop.src_a, cur_a, cur_b, cur_c, cur_d, k0_ff, k1_ff, e_ff, s_ff);
   assign unit_b = pick(uop.src_b, cur_a, cur_b, cur_c, cur_d, k0_ff, k1_ff, e_ff, s_ff);
   assign res_c  = unit_res[CW-1:0];
   assign res_v  = unit_res[VW-1:0];

   btk_unit #(
      .COORD_WIDTH (COORD_WIDTH),
      .COV_WIDTH   (COV_WIDTH)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .opa    (unit_a),
      .opb    (unit_b),
      .result (unit_res),
      .done   (unit_done)
   );

   // life bookkeeping
   assign hs_hit    = (hs_ff == 2'd3) ? 2'd3 : hs_ff + 2'd1;
   assign life_sum  = {1'b0, life_ff} + (9'd1 << hs_hit);
   assign life_hit  = (life_sum > {1'b0, life_cap_ff}) ? life_cap_ff : life_sum[7:0];
   assign life_miss = (life_ff != 8'd0) ? life_ff - 8'd1 : 8'd0;

   // predicted box: size floored at 1.0
   assign w_fl = (cx(pos_ff[2]) > ONE_L) ? cx(pos_ff[2]) : ONE_L;
   assign h_fl = (cx(pos_ff[3]) > ONE_L) ? cx(pos_ff[3]) : ONE_L;

   assign last_step = step_ff == STEP_W'(HIT_STEPS - 1);

   // ------------------------------------------------------------ next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            case (op_ff)
               OPC_PREDICT: state_in = ST_PRED1;
               OPC_HIT:     state_in = ST_ISSUE;
               default:     state_in = ST_EMIT;
            endcase
         end
         ST_PRED1:  state_in = ST_PRED2;
         ST_PRED2:  state_in = ST_PRED3;
         ST_PRED3:  state_in = ST_PRED4;
         ST_PRED4:  state_in = ST_SHOW;
         ST_SHOW:   state_in = ST_EMIT;
         ST_ISSUE:  state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT:   if (unit_done) state_in = last_step ? ST_EMIT : ST_ISSUE;
         ST_EMIT:   if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      accept          = 1'b0;
      emit_go         = 1'b0;
      unit_cmd.start  = 1'b0;
      unit_cmd.kind   = uop.kind;
      unit_cmd.narrow = (uop.dst == DST_SP) || (uop.dst == DST_SV);
      case (state_ff)
         ST_IDLE:   accept = req_valid;
         ST_LAUNCH: unit_cmd.start = 1'b1;
         ST_EMIT:   emit_go = !rsp_valid_ff || !rsp_stall;
         default:   accept = 1'b0;
      endcase
   end

   assign req_stall = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;

   // --------------------------------------------------------- control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         life_cap_ff  <= LIFE_CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            life_cap_ff <= csr_data;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------ track state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pos_ff[i] <= '0;
            pa_ff[i]  <= VW'(COV_ONE);
         end
         for (int i = 0; i < 2; i++) begin
            vel_ff[i] <= '0;
            pb_ff[i]  <= '0;
            pc_ff[i]  <= '0;
            pd_ff[i]  <= VW'(COV_ONE);
         end
         hs_ff      <= '0;
         life_ff    <= '0;
         class_ff   <= '0;
         score_ff   <= '0;
         shown_x_ff <= '0;
         shown_y_ff <= '0;
         shown_w_ff <= '0;
         shown_h_ff <= '0;
         dead_ff    <= 1'b0;
         step_ff    <= '0;
      end else begin
         case (state_ff)
            ST_DECODE: begin
               // only a miss that ends at zero life flags the track dead
               dead_ff <= (op_ff == OPC_MISS) && (life_miss == 8'd0);
               step_ff <= '0;
               case (op_ff)
                  OPC_INIT: begin
                     pos_ff[0] <= zx;
                     pos_ff[1] <= zy;
                     pos_ff[2] <= zw;
                     pos_ff[3] <= zh;
                     for (int i = 0; i < 4; i++) begin
                        pa_ff[i] <= VW'(COV_ONE);
                     end
                     for (int i = 0; i < 2; i++) begin
                        vel_ff[i] <= '0;
                        pb_ff[i]  <= '0;
                        pc_ff[i]  <= '0;
                        pd_ff[i]  <= VW'(COV_ONE);
                     end
                     hs_ff   <= '0;
                     life_ff <= life_cap_ff;
                  end
                  OPC_HIT: begin
                     hs_ff   <= hs_hit;
                     life_ff <= life_hit;
                  end
                  OPC_MISS: begin
                     hs_ff   <= '0;
                     life_ff <= life_miss;
                  end
                  default: hs_ff <= hs_ff;
               endcase
               if (op_ff == OPC_INIT || op_ff == OPC_HIT) begin
                  class_ff   <= cls_ff;
                  score_ff   <= conf_ff;
                  shown_x_ff <= bx_ff;
                  shown_y_ff <= by_ff;
                  shown_w_ff <= bw_ff;
                  shown_h_ff <= bh_ff;
               end
            end
            ST_PRED1: begin
               for (int i = 0; i < 2; i++) begin
                  pos_ff[i] <= sat_c(cx(pos_ff[i]) + cx(vel_ff[i]));
               end
            end
            ST_PRED4: begin
               for (int i = 0; i < 2; i++) begin
                  pa_ff[i] <= sat_v(vx(tmp_ff[i]) + Q_L);
                  pb_ff[i] <= sat_v(vx(pb_ff[i]) + vx(pd_ff[i]));
                  pc_ff[i] <= sat_v(vx(pc_ff[i]) + vx(pd_ff[i]));
                  pd_ff[i] <= sat_v(vx(pd_ff[i]) + Q_L);
               end
               pa_ff[2] <= sat_v(vx(pa_ff[2]) + Q_L);
               pa_ff[3] <= sat_v(vx(pa_ff[3]) + Q_L);
            end
            ST_SHOW: begin
               shown_x_ff <= sat_32(cx(pos_ff[0]) - (w_fl >>> 1));
               shown_y_ff <= sat_32(cx(pos_ff[1]) - (h_fl >>> 1));
               shown_w_ff <= (w_fl > S32_MAX) ? 31'h7fffffff : w_fl[30:0];
               shown_h_ff <= (h_fl > S32_MAX) ? 31'h7fffffff : h_fl[30:0];
            end
            ST_WAIT: begin
               if (unit_done) begin
                  step_ff <= step_ff + STEP_W'(1);
                  case (uop.dst)
                     DST_SP: pos_ff[ax]    <= sat_c(cx(cur_p) + cx(res_c));
                     DST_SV: vel_ff[ax[0]] <= sat_c(cx(vel_ff[ax[0]]) + cx(res_c));
                     DST_PA: pa_ff[ax]     <= sat_v(vx(cur_a) - vx(res_v));
                     DST_PB: pb_ff[ax[0]]  <= sat_v(vx(cur_b) - vx(res_v));
                     DST_PC: pc_ff[ax[0]]  <= sat_v(vx(cur_c) - vx(res_v));
                     DST_PD: pd_ff[ax[0]]  <= sat_v(vx(cur_d) - vx(res_v));
                     default: ;   // gains land in the scratch block
                  endcase
               end
            end
            default: step_ff <= step_ff;
         endcase
      end
   end

   // ------------------------------------------------------- payload / scratch
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= opcode_type'(req_opcode);
         bx_ff   <= req_box_x;
         by_ff   <= req_box_y;
         bw_ff   <= req_box_w;
         bh_ff   <= req_box_h;
         cls_ff  <= req_class_tag;
         conf_ff <= req_confidence;
      end
      case (state_ff)
         ST_PRED1: for (int i = 0; i < 2; i++) tmp_ff[i] <= sat_v(vx(pa_ff[i]) + vx(pb_ff[i]));
         ST_PRED2: for (int i = 0; i < 2; i++) tmp_ff[i] <= sat_v(vx(tmp_ff[i]) + vx(pc_ff[i]));
         ST_PRED3: for (int i = 0; i < 2; i++) tmp_ff[i] <= sat_v(vx(tmp_ff[i]) + vx(pd_ff[i]));
         ST_ISSUE: begin
            if (uop.first) begin
               s_ff <= s_calc;
               e_ff <= e_calc;
            end
         end
         ST_WAIT: begin
            if (unit_done && uop.dst == DST_K0) k0_ff <= res_v;
            if (unit_done && uop.dst == DST_K1) k1_ff <= res_v;
         end
         default: s_ff <= s_ff;
      endcase
      if (emit_go) begin
         rsp_x_ff       <= shown_x_ff;
         rsp_y_ff       <= shown_y_ff;
         rsp_w_ff       <= shown_w_ff;
         rsp_h_ff       <= shown_h_ff;
         rsp_class_ff   <= class_ff;
         rsp_score_ff   <= score_ff;
         rsp_life_ff    <= life_ff;
         rsp_dead_ff    <= dead_ff;
         rsp_healthy_ff <= life_ff == life_cap_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_x_ff;
   assign rsp_out_y     = rsp_y_ff;
   assign rsp_out_w     = rsp_w_ff;
   assign rsp_out_h     = rsp_h_ff;
   assign rsp_out_class = rsp_class_ff;
   assign rsp_out_score = rsp_score_ff;
   assign rsp_life_now  = rsp_life_ff;
   assign rsp_dead      = rsp_dead_ff;
   assign rsp_healthy   = rsp_healthy_ff;

   // ------------------------------------------------------------ assertions
   a_dead_life: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_dead_ff |-> rsp_life_ff == 8'd0)
      else $error("dead item with life left");
   a_floor: assert property (@(posedge clock) disable iff (reset)
      $past(state_ff == ST_SHOW) |-> (shown_w_ff >= 31'(ONE_Q16)) &&
                                     (shown_h_ff >= 31'(ONE_Q16)))
      else $error("predicted size below 1.0");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> state_ff == ST_WAIT)
      else $error("unit result outside wait");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> step_ff < STEP_W'(HIT_STEPS))
      else $error("micro-op index out of range");

endmodule

`default_nettype wire

>>> sv/btk_unit.sv
// ============================================================================
// btk_unit: shared iterative multiply / divide unit
// Radix-2 shift-add multiply and restoring divide, Q24 rescale with rounding
// to nearest (ties away from zero) and symmetric saturation.
// ============================================================================
`default_nettype none

module btk_unit #(
   parameter int COORD_WIDTH = btk_pkg::COORD_WIDTH_DEF,
   parameter int COV_WIDTH   = btk_pkg::COV_WIDTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire btk_pkg::unit_cmd_type       cmd,
   input  wire logic signed [((COORD_WIDTH > COV_WIDTH) ? COORD_WIDTH : COV_WIDTH)-1:0] opa,
   input  wire logic signed [((COORD_WIDTH > COV_WIDTH) ? COORD_WIDTH : COV_WIDTH)-1:0] opb,
   output logic signed      [((COORD_WIDTH > COV_WIDTH) ? COORD_WIDTH : COV_WIDTH)-1:0] result,
   output logic                             done
);
   import btk_pkg::*;

   localparam int OW    = (COORD_WIDTH > COV_WIDTH) ? COORD_WIDTH : COV_WIDTH;
   localparam int PW    = 2 * OW;
   localparam int NW    = OW + COV_FRAC + 1;
   localparam int RW    = (NW > PW + 1) ? NW : PW + 1;
   localparam int CNT_W = $clog2(NW + 1);

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   unit_kind_type        kind_ff;
   logic                 neg_ff;
   logic                 narrow_ff;
   logic [OW-1:0]        mcand_ff, mplier_ff, dvs_ff, rem_ff;
   logic [PW-1:0]        acc_ff;
   logic [NW-1:0]        num_ff, quo_ff;
   logic signed [OW-1:0] res_ff;

   logic [OW-1:0]        mag_a, mag_b;
   logic [OW:0]          r2;
   logic                 ge;
   logic [OW:0]          r_sub;
   logic [PW-1:0]        acc_next;
   logic [RW-1:0]        mag, lim, sat_mag;
   logic [OW-1:0]        v;

   assign mag_a = opa[OW-1] ? OW'(-opa) : OW'(opa);
   assign mag_b = opb[OW-1] ? OW'(-opb) : OW'(opb);

   assign r2       = {rem_ff, num_ff[NW-1]};
   assign ge       = r2 >= {1'b0, dvs_ff};
   assign r_sub    = ge ? (r2 - {1'b0, dvs_ff}) : r2;
   assign acc_next = {acc_ff[PW-2:0], 1'b0} + (mplier_ff[OW-1] ? PW'(mcand_ff) : '0);

   always_comb begin
      if (kind_ff == UK_MUL) begin
         mag = (RW'(acc_ff) + (RW'(1) << (COV_FRAC - 1))) >> COV_FRAC;
      end else begin
         mag = RW'(quo_ff);
      end
      lim     = narrow_ff ? ((RW'(1) << (COORD_WIDTH - 1)) - RW'(1))
                          : ((RW'(1) << (COV_WIDTH - 1)) - RW'(1));
      sat_mag = (mag > lim) ? lim : mag;
      v       = sat_mag[OW-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      cnt_in  = cnt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = (cmd.kind == UK_DIV) ? CNT_W'(NW) : CNT_W'(OW);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff   <= cmd.kind;
         narrow_ff <= cmd.narrow;
         if (cmd.kind == UK_DIV) begin
            neg_ff <= opa[OW-1];
            num_ff <= (NW'(mag_a) << COV_FRAC) + NW'(opb >> 1);
            dvs_ff <= opb;
            rem_ff <= '0;
            quo_ff <= '0;
         end else begin
            neg_ff    <= opa[OW-1] ^ opb[OW-1];
            mcand_ff  <= mag_a;
            mplier_ff <= mag_b;
            acc_ff    <= '0;
         end
      end else if (busy_ff) begin
         if (kind_ff == UK_DIV) begin
            num_ff <= {num_ff[NW-2:0], 1'b0};
            rem_ff <= r_sub[OW-1:0];
            quo_ff <= {quo_ff[NW-2:0], ge};
         end else begin
            acc_ff    <= acc_next;
            mplier_ff <= {mplier_ff[OW-2:0], 1'b0};
         end
      end
      if (fin_ff) begin
         res_ff <= neg_ff ? -$signed(v) : $signed(v);
      end
   end

   assign result = res_ff;
   assign done   = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff && !fin_ff)
      else $error("unit started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done longer than one cycle");
   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("busy with empty count");

endmodule

`default_nettype wire
